// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds default geometry, field widths, operation and status codes, the
// sequencer state type and the control word of the shared adder.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Default heap geometry in bytes.
  localparam int unsigned HEAP_BYTES_DEF   = 32 * 1024;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  // Fixed widths of the request and response fields.
  localparam int unsigned REQ_W    = 16;
  localparam int unsigned OFF_W    = 15;
  localparam int unsigned STATUS_W = 2;
  // A rounded-up request can reach 2**REQ_W.
  localparam int unsigned NEED_W   = REQ_W + 1;

  // Request operation codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_FIT,
    S_A_SPL,
    S_A_TAIL,
    S_A_HDR,
    S_A_NXT,
    S_F_RD,
    S_F_CMP,
    S_F_NXT,
    S_F_MARK,
    S_M_RD,
    S_M_HDR,
    S_M_NXT,
    S_M_RDN,
    S_M_PAIR,
    S_RESP
  } state_e;

  // Control word of the shared adder.
  typedef struct packed {
    logic sub;      // a - b instead of a + b
    logic add_hdr;  // also add the header size
  } alu_ctl_t;

endpackage

// ===== sv/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_if: request and response channels of the heap allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  import ffha_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] user_offset;

  modport source (output valid, action, request_bytes, user_offset, input ready);
  modport sink   (input valid, action, request_bytes, user_offset, output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

// ===== sv/ffha_alu.sv =====
// ----------------------------------------------------------------------------
// ffha_alu: shared adder of the allocator
// One add/subtract unit that can also add the header size. All offsets,
// fit compares and merged sizes of the sequencer go through it.
// ----------------------------------------------------------------------------
module ffha_alu #(
  parameter int unsigned W   = 19,
  parameter int unsigned HDR = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  ffha_pkg::alu_ctl_t ctl_i,
  output logic [W-1:0]       sum_o
);
  import ffha_pkg::*;

  logic [W-1:0] b_op;
  logic [W-1:0] k_op;

  // Two's complement subtract by inverting b and adding one.
  assign b_op  = ctl_i.sub ? ~b_i : b_i;
  assign k_op  = ctl_i.add_hdr ? W'(HDR) : '0;
  assign sum_o = a_i + b_op + k_op + W'(ctl_i.sub);

endmodule

// ===== sv/ffha_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_mem: block header store
// One header word per 4-byte slot of the heap, one write and one registered
// read port. Only the first word has a reset value; a flag stands in for it
// until that word is written for the first time.
// ----------------------------------------------------------------------------
module ffha_hdr_mem #(
  parameter int unsigned    AW   = 13,
  parameter int unsigned    DW   = 16,
  parameter logic [DW-1:0]  INIT = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);
  import ffha_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_q;
  logic          init_q;
  logic          rd_init_q;

  // Storage array with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Word zero reads as its reset value until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b1;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i && (wr_addr_i == '0)) begin
        init_q <= 1'b0;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q && (rd_addr_i == '0);
      end
    end
  end

  assign rd_data_o = rd_init_q ? INIT : rd_q;

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over a chain of block headers
// A request on req_i either allocates request_bytes (rounded up to a multiple
// of 4) from the first free block large enough, splitting off the tail when
// it is big enough, or frees the block at user_offset and then merges all
// runs of adjacent free blocks in one pass over the chain. Each request gives
// exactly one response on rsp_o: a status and, for a granted allocation, the
// user offset just past the block header.
// One request is worked on at a time; req_i.ready is high only while idle.
// An allocate reads, checks and steps past each block header before the fit,
// then works out the split, writes the tail header when it splits, writes
// the granted header and hands off. A free reads, compares and steps past
// each block before the target, marks it free, then makes the merge pass
// over the chain (a merge stays on its block) and hands off.
// The pace is set by the single read port of the header store and the one
// shared adder that every offset, fit compare and merged size goes through.
// Requests of size zero and frees of null go straight to the hand-off.
// Reset empties the heap into one free block at once; no clearing pass.
// The response sits in an output register; while the receiver stalls, the
// next request is still taken and worked on up to its response.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  ffha_req_if.sink  req_i,
  ffha_rsp_if.source rsp_o
);
  import ffha_pkg::*;

  // Offsets and sizes fit in AW bits; the adder has headroom for a sign.
  localparam int unsigned AW  = $clog2(HEAP_BYTES);
  localparam int unsigned MAW = AW - 2;
  localparam int unsigned HW  = AW + 1;
  localparam int unsigned CW  = ((AW > NEED_W) ? AW : NEED_W) + 2;
  localparam logic [HW-1:0] HDR_INIT = {1'b1, AW'(HEAP_BYTES - HEADER_BYTES)};

  state_e state_q, state_d;

  logic [AW-1:0]     cur_q;
  logic [AW-1:0]     nxt_q;
  logic [HW-1:0]     hdr_q;
  logic [NEED_W-1:0] need_q;
  logic [CW-1:0]     diff_q;
  logic [AW-1:0]     tail_q;
  logic              split_q;
  logic [OFF_W-1:0]  uoff_q;
  status_e           res_status_q;
  logic [OFF_W-1:0]  res_off_q;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [OFF_W-1:0]  out_off_q;

  logic          rd_en;
  logic [MAW-1:0] rd_addr;
  logic [HW-1:0] rd_data;
  logic          wr_en;
  logic [MAW-1:0] wr_addr;
  logic [HW-1:0] wr_data;

  logic [CW-1:0] alu_a;
  logic [CW-1:0] alu_b;
  alu_ctl_t      alu_ctl;
  logic [CW-1:0] alu_sum;

  logic [AW-1:0] rd_size;
  logic          rd_free;
  logic [AW-1:0] hdr_size;
  logic          hdr_free;
  logic          accept;
  logic          load_out;
  logic          fit;
  logic          at_end;
  logic          match;
  logic          split;
  logic          merge;

  // Header store and shared adder.
  ffha_hdr_mem #(
    .AW   (MAW),
    .DW   (HW),
    .INIT (HDR_INIT)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ffha_alu #(
    .W   (CW),
    .HDR (HEADER_BYTES)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ctl_i (alu_ctl),
    .sum_o (alu_sum)
  );

  // Header fields and decisions taken from the adder result.
  assign rd_size  = rd_data[AW-1:0];
  assign rd_free  = rd_data[AW];
  assign hdr_size = hdr_q[AW-1:0];
  assign hdr_free = hdr_q[AW];
  assign fit      = rd_free && !alu_sum[CW-1];
  assign at_end   = alu_sum >= CW'(HEAP_BYTES);
  assign match    = alu_sum == CW'(uoff_q);
  assign split    = diff_q > CW'(HEADER_BYTES + 4);
  assign merge    = hdr_free && rd_free;

  // Handshakes.
  assign req_i.ready          = (state_q == S_IDLE);
  assign accept               = req_i.valid && req_i.ready;
  assign load_out             = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.granted_offset = out_off_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_ALLOC) begin
            state_d = (req_i.request_bytes == '0) ? S_RESP : S_A_RD;
          end else begin
            state_d = (req_i.user_offset == '0) ? S_RESP : S_F_RD;
          end
        end
      end
      S_A_RD:   state_d = S_A_FIT;
      S_A_FIT:  state_d = fit ? S_A_SPL : S_A_NXT;
      S_A_SPL:  state_d = split ? S_A_TAIL : S_A_HDR;
      S_A_TAIL: state_d = S_A_HDR;
      S_A_HDR:  state_d = S_RESP;
      S_A_NXT:  state_d = at_end ? S_RESP : S_A_RD;
      S_F_RD:   state_d = S_F_CMP;
      S_F_CMP:  state_d = match ? S_F_MARK : S_F_NXT;
      S_F_NXT:  state_d = at_end ? S_RESP : S_F_RD;
      S_F_MARK: state_d = S_M_RD;
      S_M_RD:   state_d = S_M_HDR;
      S_M_HDR:  state_d = S_M_NXT;
      S_M_NXT:  state_d = at_end ? S_RESP : S_M_RDN;
      S_M_RDN:  state_d = S_M_PAIR;
      S_M_PAIR: state_d = S_M_NXT;
      S_RESP:   state_d = load_out ? S_IDLE : S_RESP;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory port and adder operands for each state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q[AW-1:2];
    wr_en   = 1'b0;
    wr_addr = cur_q[AW-1:2];
    wr_data = hdr_q;
    alu_a   = CW'(cur_q);
    alu_b   = CW'(hdr_size);
    alu_ctl = '{sub: 1'b0, add_hdr: 1'b1};
    unique case (state_q)
      S_A_RD, S_F_RD, S_M_RD: begin
        rd_en = 1'b1;
      end
      S_M_RDN: begin
        rd_en   = 1'b1;
        rd_addr = nxt_q[AW-1:2];
      end
      S_A_FIT: begin
        alu_a   = CW'(rd_size);
        alu_b   = CW'(need_q);
        alu_ctl = '{sub: 1'b1, add_hdr: 1'b0};
      end
      S_A_SPL: begin
        alu_a   = diff_q;
        alu_b   = CW'(HEADER_BYTES);
        alu_ctl = '{sub: 1'b1, add_hdr: 1'b0};
      end
      S_A_TAIL: begin
        // Tail block header sits right after the granted payload.
        alu_b   = CW'(need_q);
        wr_en   = 1'b1;
        wr_addr = alu_sum[AW-1:2];
        wr_data = {1'b1, tail_q};
      end
      S_A_HDR: begin
        alu_b   = '0;
        wr_en   = 1'b1;
        wr_data = {1'b0, (split_q ? AW'(need_q) : hdr_size)};
      end
      S_F_CMP: begin
        alu_b = '0;
      end
      S_F_MARK: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, hdr_size};
      end
      S_M_PAIR: begin
        alu_a   = CW'(hdr_size);
        alu_b   = CW'(rd_size);
        wr_en   = merge;
        wr_data = {1'b1, alu_sum[AW-1:0]};
      end
      default: begin
        // Walk steps use the default: next offset = cur + header + size.
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register is loaded from a finished request, emptied by a transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cur_q        <= '0;
          res_off_q    <= '0;
          uoff_q       <= req_i.user_offset;
          need_q       <= {15'(req_i.request_bytes[REQ_W-1:2]) +
                           15'(|req_i.request_bytes[1:0]), 2'b00};
          res_status_q <= (req_i.action == ACT_ALLOC) ? ST_FAIL : ST_IGNORED;
        end
      end
      S_A_FIT: begin
        hdr_q  <= rd_data;
        diff_q <= alu_sum;
      end
      S_A_SPL: begin
        tail_q  <= alu_sum[AW-1:0];
        split_q <= split;
      end
      S_A_HDR: begin
        res_off_q    <= alu_sum[OFF_W-1:0];
        res_status_q <= ST_DONE;
      end
      S_A_NXT, S_F_NXT: begin
        cur_q <= alu_sum[AW-1:0];
      end
      S_F_CMP, S_M_HDR: begin
        hdr_q <= rd_data;
      end
      S_F_MARK: begin
        cur_q        <= '0;
        res_status_q <= ST_DONE;
      end
      S_M_NXT: begin
        nxt_q <= alu_sum[AW-1:0];
      end
      S_M_PAIR: begin
        // A merge stays on this block; otherwise step to the next one.
        if (merge) begin
          hdr_q <= {1'b1, alu_sum[AW-1:0]};
        end else begin
          cur_q <= nxt_q;
          hdr_q <= rd_data;
        end
      end
      S_RESP: begin
        if (load_out) begin
          out_status_q <= res_status_q;
          out_off_q    <= res_off_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks of the heap allocator
// Watches the request and response channels of the top level and is bound
// to it below.
// ----------------------------------------------------------------------------
module ffha_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ffha_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [ffha_pkg::OFF_W-1:0]    rsp_granted_i
);
  import ffha_pkg::*;

  // A stalled response stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_granted_i))
    else $error("response payload changed while stalled");

  // The block does not take a request in the cycle after it takes one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a previous one is in work");

  // Only a completed allocation grants a non-null offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_granted_i != '0) |-> (rsp_status_i == ST_DONE))
    else $error("offset granted with a failure status");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_granted_i (rsp_o.granted_offset)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the first-fit heap allocator
// A scoreboard keeps its own copy of the block header chain and works out
// the status and granted offset of every request at the moment it is taken.
// Directed requests cover the edges of the heap, then random allocate and
// free mixes run with random gaps on both channels and one long hold-off on
// the response side.
// ----------------------------------------------------------------------------
module tb_top;
  import ffha_pkg::*;

  localparam int unsigned HEAP_B   = HEAP_BYTES_DEF;
  localparam int unsigned HDR_B    = HEADER_BYTES_DEF;
  localparam int          N_RANDOM = 1700;
  localparam int          LIVE_CAP = 24;
  localparam int          HOLD_CYC = 400;
  localparam int          DRAIN    = 64;
  // A walk over a fully fragmented heap is long; the limit allows several
  // such walks plus the hold-off before giving up.
  localparam int          IDLE_LIMIT = 50000;

  // One header entry: free flag and payload size.
  typedef struct packed {
    bit           is_free;
    bit [OFF_W-1:0] size;
  } blk_hdr_t;

  typedef struct {
    status_e          status;
    logic [OFF_W-1:0] granted;
  } heap_rsp_t;

  // Scoreboard: header chain mirror, awaited responses and live blocks.
  class heap_scoreboard;
    blk_hdr_t    hdr_mem [HEAP_B];
    heap_rsp_t   awaited_rsp_q[$];
    int unsigned live_q[$];
    int unsigned released_q[$];
    int          errors;

    function new();
      foreach (hdr_mem[i]) hdr_mem[i] = '0;
      hdr_mem[0] = '{1'b1, OFF_W'(HEAP_B - HDR_B)};
      errors = 0;
    endfunction

    function int unsigned next_block(int unsigned o);
      int unsigned n;
      n = o + HDR_B + hdr_mem[o].size;
      return (n >= HEAP_B) ? HEAP_B : n;
    endfunction

    // First free block that fits; split when the tail can hold a block.
    function int unsigned first_fit_grant(int unsigned req);
      int unsigned need;
      int unsigned sz;
      int unsigned o;
      if (req == 0) return 0;
      need = (req + 3) & ~32'd3;
      o = 0;
      while (o < HEAP_B) begin
        sz = hdr_mem[o].size;
        if (hdr_mem[o].is_free && sz >= need) begin
          if (sz > need + HDR_B + 4) begin
            hdr_mem[o + HDR_B + need] = '{1'b1, OFF_W'(sz - need - HDR_B)};
            sz = need;
          end
          hdr_mem[o] = '{1'b0, OFF_W'(sz)};
          return o + HDR_B;
        end
        o = next_block(o);
      end
      return 0;
    endfunction

    // Mark the block free, then merge every run of free neighbors.
    function bit release_and_merge(int unsigned uoff);
      int unsigned o;
      int unsigned n;
      if (uoff < HDR_B) return 1'b0;
      o = 0;
      while (o < HEAP_B && o + HDR_B != uoff) o = next_block(o);
      if (o >= HEAP_B) return 1'b0;
      hdr_mem[o].is_free = 1'b1;
      o = 0;
      while (o < HEAP_B) begin
        n = next_block(o);
        if (n >= HEAP_B) break;
        if (hdr_mem[o].is_free && hdr_mem[n].is_free)
          hdr_mem[o].size = OFF_W'(hdr_mem[o].size + HDR_B + hdr_mem[n].size);
        else
          o = n;
      end
      return 1'b1;
    endfunction

    // Called on every request transfer.
    function void note_request(logic act, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
      heap_rsp_t   r;
      int unsigned g;
      r.granted = '0;
      if (act == ACT_ALLOC) begin
        g = first_fit_grant(req);
        r.status  = (g == 0) ? ST_FAIL : ST_DONE;
        r.granted = OFF_W'(g);
        if (g != 0) live_q.push_back(g);
      end else if (off != 0 && release_and_merge(off)) begin
        r.status = ST_DONE;
        for (int i = 0; i < live_q.size(); i++) begin
          if (live_q[i] == off) begin
            live_q.delete(i);
            break;
          end
        end
        released_q.push_back(off);
        if (released_q.size() > 16) void'(released_q.pop_front());
      end else begin
        r.status = ST_IGNORED;
      end
      awaited_rsp_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    // Called on every response transfer.
    task check_response(logic [STATUS_W-1:0] st, logic [OFF_W-1:0] off);
      heap_rsp_t e;
      if (awaited_rsp_q.size() == 0) begin
        report($sformatf("response status=%0d offset=%0d with none awaited", st, off));
      end else begin
        e = awaited_rsp_q.pop_front();
        if (st !== e.status)
          report($sformatf("status %0d, awaited %0d", st, e.status));
        if (off !== e.granted)
          report($sformatf("granted_offset %0d, awaited %0d", off, e.granted));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  heap_scoreboard sb;
  int             n_sent;
  int             n_done;
  bit             held_off;

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Offer one request after a random gap and hold it until the transfer.
  task automatic send_item(logic act, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    int gap;
    gap = ((n_sent / 50) % 4 == 1) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.request_bytes <= req;
    req_if.user_offset   <= off;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(act, req, off);
    n_sent++;
  endtask

  // Free every live block in random order.
  task automatic release_all();
    while (sb.live_q.size() != 0)
      send_item(ACT_FREE, '0, OFF_W'(sb.live_q[$urandom_range(0, sb.live_q.size() - 1)]));
  endtask

  // Request side: directed part, random part, then the end of the run.
  initial begin : req_side
    int          pick;
    int          sel;
    logic [REQ_W-1:0] sz;
    sb       = new();
    n_sent   = 0;
    n_done   = 0;
    held_off = 1'b0;
    req_if.valid         <= 1'b0;
    req_if.action        <= ACT_ALLOC;
    req_if.request_bytes <= '0;
    req_if.user_offset   <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Zero size, null free, whole heap, no fit, oversize requests.
    send_item(ACT_ALLOC, 16'd0, '0);
    send_item(ACT_FREE, 16'd0, '0);
    send_item(ACT_ALLOC, 16'(HEAP_B - HDR_B), '0);
    send_item(ACT_ALLOC, 16'd4, '0);
    send_item(ACT_FREE, '0, OFF_W'(HDR_B));
    send_item(ACT_ALLOC, 16'(HEAP_B - HDR_B + 1), '0);
    send_item(ACT_ALLOC, 16'hFFFF, '0);
    send_item(ACT_ALLOC, 16'h8000, '0);
    // Rounding, splitting, double free and unknown offsets.
    send_item(ACT_ALLOC, 16'd1, '0);
    send_item(ACT_ALLOC, 16'd3, '0);
    send_item(ACT_ALLOC, 16'd5, '0);
    send_item(ACT_FREE, '0, OFF_W'(2 * HDR_B + 4));
    send_item(ACT_FREE, '0, OFF_W'(2 * HDR_B + 4));
    send_item(ACT_FREE, '0, OFF_W'(HDR_B + 1));
    send_item(ACT_FREE, '0, 15'h7FFF);
    send_item(ACT_ALLOC, 16'd4, '0);
    release_all();
    // Right at the split threshold, then just past it with a tiny tail.
    send_item(ACT_ALLOC, 16'(HEAP_B - 2 * HDR_B - 4), '0);
    release_all();
    send_item(ACT_ALLOC, 16'(HEAP_B - 2 * HDR_B - 8), '0);
    send_item(ACT_ALLOC, 16'd8, '0);
    release_all();

    // Random mix: mostly valid allocate/free pairs, some noise.
    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      if (k % 400 == 399) begin
        release_all();
      end else if (sb.live_q.size() > 0 && (pick < 40 || sb.live_q.size() >= LIVE_CAP)) begin
        sel = $urandom_range(0, sb.live_q.size() - 1);
        send_item(ACT_FREE, REQ_W'($urandom()), OFF_W'(sb.live_q[sel]));
      end else if (pick < 86) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      sz = REQ_W'($urandom_range(1, 64));
        else if (sel < 90) sz = REQ_W'($urandom_range(65, 1024));
        else if (sel < 98) sz = REQ_W'($urandom_range(1025, 8192));
        else               sz = REQ_W'($urandom_range(8193, 32768));
        send_item(ACT_ALLOC, sz, OFF_W'($urandom()));
      end else begin
        case ($urandom_range(0, 4))
          0: send_item(ACT_ALLOC, '0, OFF_W'($urandom()));
          1: send_item(ACT_FREE, REQ_W'($urandom()), '0);
          2: send_item(ACT_FREE, REQ_W'($urandom()), OFF_W'($urandom()));
          3: begin
            if (sb.released_q.size() != 0)
              send_item(ACT_FREE, '0,
                        OFF_W'(sb.released_q[$urandom_range(0, sb.released_q.size() - 1)]));
            else
              send_item(ACT_FREE, '0, OFF_W'($urandom()));
          end
          default: send_item(ACT_ALLOC, REQ_W'($urandom_range(32757, 65535)), '0);
        endcase
      end
    end
    req_if.valid <= 1'b0;

    // Wait for every awaited response, then for stray ones.
    while (sb.awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_rsp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Response side: random stalls and one long hold-off while requests queue.
  initial begin : rsp_side
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && n_sent >= 200) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end
      stall = ((n_done / 70) % 4 == 2) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check_response(rsp_if.status, rsp_if.granted_offset);
      n_done++;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
